### sv/swa_pkg.sv
package swa_pkg;

	// Q0.16 fraction bits and width of a semblance value (1.0 included)
	localparam int unsigned SEMB_FRAC = 16;
	localparam int unsigned SEMB_W    = 17;
	localparam logic [SEMB_W-1:0] SEMB_ONE = 17'h10000;

	// controller states
	typedef enum logic [3:0] {
		S_IDLE,
		S_LOAD,
		S_MUL,
		S_RATIO,
		S_DIV,
		S_TOTAL,
		S_AVG_LOAD,
		S_AVG,
		S_DONE
	} swa_state_t;

	// controller -> datapath commands
	typedef struct packed {
		logic accum;
		logic load;
		logic mul_step;
		logic ratio;
		logic div_step;
		logic total;
		logic avg_load;
		logic avg_step;
		logic publish;
	} swa_cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic win;
		logic out_free;
	} swa_stat_t;

endpackage

### sv/swa_ctrl.sv
module swa_ctrl #(
	parameter int unsigned MUL_STEPS = 24,
	parameter int unsigned AVG_STEPS = 28
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               last_trace,
	output logic               in_stall,
	input  swa_pkg::swa_stat_t stat,
	output swa_pkg::swa_cmd_t  cmd
);

	localparam int unsigned MAX_STEPS = (MUL_STEPS > AVG_STEPS) ?
		((MUL_STEPS > swa_pkg::SEMB_FRAC) ? MUL_STEPS : swa_pkg::SEMB_FRAC) :
		((AVG_STEPS > swa_pkg::SEMB_FRAC) ? AVG_STEPS : swa_pkg::SEMB_FRAC);
	localparam int unsigned CNTW = $clog2(MAX_STEPS + 1);

	localparam logic [CNTW-1:0] MUL_LAST = CNTW'(MUL_STEPS - 1);
	localparam logic [CNTW-1:0] DIV_LAST = CNTW'(swa_pkg::SEMB_FRAC - 1);
	localparam logic [CNTW-1:0] AVG_LAST = CNTW'(AVG_STEPS - 1);

	swa_pkg::swa_state_t state_q, state_d;
	logic [CNTW-1:0]     cnt_q, cnt_d;

	// state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swa_pkg::S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			swa_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.accum = 1'b1;
					if (last_trace)
						state_d = swa_pkg::S_LOAD;
				end
			end
			swa_pkg::S_LOAD: begin
				cmd.load = 1'b1;
				cnt_d    = '0;
				state_d  = swa_pkg::S_MUL;
			end
			swa_pkg::S_MUL: begin
				cmd.mul_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == MUL_LAST) begin
					cnt_d   = '0;
					state_d = swa_pkg::S_RATIO;
				end
			end
			swa_pkg::S_RATIO: begin
				cmd.ratio = 1'b1;
				state_d   = swa_pkg::S_DIV;
			end
			swa_pkg::S_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == DIV_LAST) begin
					cnt_d   = '0;
					state_d = swa_pkg::S_TOTAL;
				end
			end
			swa_pkg::S_TOTAL: begin
				cmd.total = 1'b1;
				state_d   = stat.win ? swa_pkg::S_AVG_LOAD : swa_pkg::S_DONE;
			end
			swa_pkg::S_AVG_LOAD: begin
				cmd.avg_load = 1'b1;
				state_d      = swa_pkg::S_AVG;
			end
			swa_pkg::S_AVG: begin
				cmd.avg_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == AVG_LAST) begin
					cnt_d   = '0;
					state_d = swa_pkg::S_DONE;
				end
			end
			swa_pkg::S_DONE: begin
				if (stat.out_free) begin
					cmd.publish = 1'b1;
					state_d     = swa_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = swa_pkg::S_IDLE;
			end
		endcase
	end

endmodule

### sv/swa_dp.sv
module swa_dp #(
	parameter int unsigned MAX_TRACES  = 256,
	parameter int unsigned MAX_SAMPLES = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  swa_pkg::swa_cmd_t                 cmd,
	output swa_pkg::swa_stat_t                stat,
	input  logic signed [15:0]                sample,
	input  logic                              last_sample,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [swa_pkg::SEMB_W-1:0]        sample_semblance,
	output logic [swa_pkg::SEMB_W-1:0]        window_semblance,
	output logic                              window_done
);

	localparam int unsigned SW  = swa_pkg::SEMB_W;
	localparam int unsigned FW  = swa_pkg::SEMB_FRAC;
	localparam int unsigned TW  = $clog2(MAX_TRACES + 1);
	localparam int unsigned AW  = 17 + $clog2(MAX_TRACES);
	localparam int unsigned MGW = AW - 1;
	localparam int unsigned EW  = 31 + $clog2(MAX_TRACES);
	localparam int unsigned NW  = 2 * MGW;
	localparam int unsigned DNW = TW + EW;
	localparam int unsigned CW  = (NW > DNW) ? NW : DNW;
	localparam int unsigned STW = $clog2(MAX_SAMPLES + 1);
	localparam int unsigned TTW = 17 + STW;

	// per-time-sample accumulators
	logic signed [AW-1:0] amp_sum_q;
	logic [EW-1:0]        energy_q;
	logic [TW-1:0]        trace_tally_q;
	logic                 win_q;

	// serial multipliers for S*S and n*E
	logic [NW-1:0]  mcand_q, num_q;
	logic [MGW-1:0] mplier_q;
	logic [DNW-1:0] dcand_q, den_q;
	logic [TW-1:0]  dplier_q;
	logic           ezero_q;

	// Q16 ratio divider
	logic [CW:0]    rem_q;
	logic [FW-1:0]  quot_q;
	logic           one_q;
	logic [SW-1:0]  semb_q;

	// window total and average divider
	logic [TTW-1:0] total_q;
	logic [STW-1:0] stally_q;
	logic [TTW-1:0] dq_q;
	logic [STW-1:0] arem_q;

	// output register
	logic           out_valid_q;
	logic [SW-1:0]  sample_semblance_q, window_semblance_q;
	logic           window_done_q;

	logic signed [31:0] sq_full;
	logic [30:0]        sq;
	logic signed [AW-1:0] amp_abs;
	logic [MGW-1:0]     mag;
	logic [CW-1:0]      numc, denc;
	logic [CW:0]        div_sh, den_ext;
	logic               div_ge;
	logic [SW-1:0]      semb_val;
	logic [STW:0]       avg_sh, avg_dv;
	logic               avg_ge;
	logic [SW-1:0]      avg_val;

	// square of the input and magnitude of the sum
	always_comb begin
		sq_full = 32'(sample) * 32'(sample);
		sq      = sq_full[30:0];
		amp_abs = (amp_sum_q < 0) ? -amp_sum_q : amp_sum_q;
		mag     = amp_abs[MGW-1:0];
		numc    = CW'(num_q);
		denc    = CW'(den_q);
	end

	// restoring step of the ratio divider
	always_comb begin
		div_sh  = {rem_q[CW-1:0], 1'b0};
		den_ext = (CW + 1)'(den_q);
		div_ge  = (div_sh >= den_ext);
	end

	always_comb begin
		if (ezero_q)
			semb_val = '0;
		else if (one_q)
			semb_val = swa_pkg::SEMB_ONE;
		else
			semb_val = SW'(quot_q);
	end

	// restoring step of the average divider
	always_comb begin
		avg_sh = {arem_q, dq_q[TTW-1]};
		avg_dv = (STW + 1)'(stally_q);
		avg_ge = (avg_sh >= avg_dv);
		avg_val = (stally_q == '0) ? '0 : dq_q[SW-1:0];
	end

	// accumulators and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_sum_q     <= '0;
			energy_q      <= '0;
			trace_tally_q <= '0;
			total_q       <= '0;
			stally_q      <= '0;
			win_q         <= 1'b0;
		end else begin
			if (cmd.accum) begin
				win_q <= last_sample;
				if (trace_tally_q < TW'(MAX_TRACES)) begin
					amp_sum_q     <= amp_sum_q + AW'(sample);
					energy_q      <= energy_q + EW'(sq);
					trace_tally_q <= trace_tally_q + 1'b1;
				end
			end
			if (cmd.load) begin
				amp_sum_q     <= '0;
				energy_q      <= '0;
				trace_tally_q <= '0;
			end
			if (cmd.total && (stally_q < STW'(MAX_SAMPLES))) begin
				total_q  <= total_q + TTW'(semb_val);
				stally_q <= stally_q + 1'b1;
			end
			if (cmd.publish && win_q) begin
				total_q  <= '0;
				stally_q <= '0;
			end
		end
	end

	// multiply, divide and average work registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mcand_q  <= NW'(mag);
			mplier_q <= mag;
			num_q    <= '0;
			dcand_q  <= DNW'(energy_q);
			dplier_q <= trace_tally_q;
			den_q    <= '0;
			ezero_q  <= (energy_q == '0);
		end
		if (cmd.mul_step) begin
			if (mplier_q[0])
				num_q <= num_q + mcand_q;
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
			if (dplier_q[0])
				den_q <= den_q + dcand_q;
			dcand_q  <= dcand_q << 1;
			dplier_q <= dplier_q >> 1;
		end
		if (cmd.ratio) begin
			rem_q  <= {1'b0, numc};
			quot_q <= '0;
			one_q  <= (numc >= denc);
		end
		if (cmd.div_step) begin
			rem_q  <= div_ge ? (div_sh - den_ext) : div_sh;
			quot_q <= {quot_q[FW-2:0], div_ge};
		end
		if (cmd.total)
			semb_q <= semb_val;
		if (cmd.avg_load) begin
			dq_q   <= total_q;
			arem_q <= '0;
		end
		if (cmd.avg_step) begin
			arem_q <= avg_ge ? STW'(avg_sh - avg_dv) : avg_sh[STW-1:0];
			dq_q   <= {dq_q[TTW-2:0], avg_ge};
		end
		if (cmd.publish) begin
			sample_semblance_q <= semb_q;
			window_semblance_q <= win_q ? avg_val : '0;
			window_done_q      <= win_q;
		end
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.publish)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	assign stat.win      = win_q;
	assign stat.out_free = !out_valid_q || !out_stall;

	assign out_valid        = out_valid_q;
	assign sample_semblance = sample_semblance_q;
	assign window_semblance = window_semblance_q;
	assign window_done      = window_done_q;

endmodule

### sv/semblance_window_average.sv
// Channel   Direction  Handshake            Word
// input     in         in_valid / in_stall  sample, last_trace, last_sample
// output    out        out_valid / out_stall sample_semblance, window_semblance, window_done
//
// A word without last_trace is taken as soon as it is offered while the block is idle. A word with last_trace
// then runs the bit-serial S*S / n*E multiplier (MGW = 16 + clog2(MAX_TRACES) multiplier bits)
// and the 16-step ratio divider; a window close also runs the serial average divider
// (TTW = 17 + clog2(MAX_SAMPLES+1) quotient bits). in_stall stays high until the block is idle again.
// Reset clears the trace and window accumulators. A finished word waits in the output register;
// the next semblance waits only if that register is still held by out_stall.
module semblance_window_average #(
	parameter int unsigned MAX_TRACES  = 256,
	parameter int unsigned MAX_SAMPLES = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [15:0]         sample,
	input  logic                       last_trace,
	input  logic                       last_sample,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [swa_pkg::SEMB_W-1:0] sample_semblance,
	output logic [swa_pkg::SEMB_W-1:0] window_semblance,
	output logic                       window_done
);

	localparam int unsigned MUL_STEPS = 16 + $clog2(MAX_TRACES);
	localparam int unsigned AVG_STEPS = 17 + $clog2(MAX_SAMPLES + 1);

	swa_pkg::swa_cmd_t  cmd;
	swa_pkg::swa_stat_t stat;

	swa_ctrl #(
		.MUL_STEPS (MUL_STEPS),
		.AVG_STEPS (AVG_STEPS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.last_trace (last_trace),
		.in_stall   (in_stall),
		.stat       (stat),
		.cmd        (cmd)
	);

	swa_dp #(
		.MAX_TRACES  (MAX_TRACES),
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.sample           (sample),
		.last_sample      (last_sample),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.sample_semblance (sample_semblance),
		.window_semblance (window_semblance),
		.window_done      (window_done)
	);

endmodule

### verif/tb_semblance_window_average.sv
`timescale 1ns / 1ps

module tb_semblance_window_average;

	localparam int unsigned SW           = swa_pkg::SEMB_W;
	localparam int unsigned TRACE_CAP    = 256;
	localparam int unsigned SAMPLE_CAP   = 1024;
	localparam int unsigned IDLE_LIMIT   = 4000;
	localparam int unsigned TAIL_CYCLES  = 120;
	localparam int unsigned RANDOM_WORDS = 220;
	localparam int unsigned MAX_REPORTS  = 10;
	localparam int          DIR_N        = 19;

	// amplitude styles for generated time samples
	typedef enum int unsigned {AMP_ANY, AMP_COHERENT, AMP_TINY, AMP_EXTREME} amp_style_t;

	typedef struct packed {
		logic [SW-1:0] semb;
		logic [SW-1:0] win;
		logic          done;
	} coh_word_t;

	typedef struct packed {
		logic signed [15:0] amp;
		logic               lt;
		logic               ls;
		logic               fixed;
		coh_word_t          want;
	} dir_row_t;

	// directed words; fixed rows carry the result that is obvious by hand
	localparam dir_row_t DIR_TAB [DIR_N] = '{
		'{16'sh0000, 1'b1, 1'b0, 1'b1, '{17'd0,     17'd0,     1'b0}}, // zero energy
		'{16'sh7FFF, 1'b1, 1'b1, 1'b1, '{17'd65536, 17'd32768, 1'b1}}, // one trace, close
		'{16'sh8000, 1'b0, 1'b0, 1'b0, '0},
		'{16'sh8000, 1'b1, 1'b0, 1'b1, '{17'd65536, 17'd0,     1'b0}}, // most negative pair
		'{16'sh7FFF, 1'b0, 1'b1, 1'b0, '0},                            // stray window mark
		'{16'sh8001, 1'b1, 1'b0, 1'b1, '{17'd0,     17'd0,     1'b0}}, // cancels to zero sum
		'{16'sh0000, 1'b0, 1'b0, 1'b0, '0},
		'{16'sh0000, 1'b1, 1'b1, 1'b1, '{17'd0,     17'd21845, 1'b1}}, // mean of 1, 0, 0
		'{16'sh0001, 1'b0, 1'b0, 1'b0, '0},
		'{16'sh0002, 1'b0, 1'b0, 1'b0, '0},
		'{16'shFFFD, 1'b1, 1'b0, 1'b0, '0},
		'{16'sh0064, 1'b0, 1'b0, 1'b0, '0},
		'{16'sh0032, 1'b1, 1'b0, 1'b0, '0},
		'{16'sh5555, 1'b0, 1'b0, 1'b0, '0},
		'{16'shAAAA, 1'b1, 1'b0, 1'b0, '0},
		'{16'shFFFF, 1'b0, 1'b1, 1'b0, '0},
		'{16'shFFFF, 1'b1, 1'b1, 1'b0, '0},
		'{16'sh7FFF, 1'b1, 1'b1, 1'b1, '{17'd65536, 17'd65536, 1'b1}}, // one-sample window
		'{16'sh8000, 1'b1, 1'b1, 1'b1, '{17'd65536, 17'd65536, 1'b1}}
	};

	logic                    clk         = 1'b0;
	logic                    arst_n      = 1'b0;
	logic                    in_valid    = 1'b0;
	logic                    in_stall;
	logic signed [15:0]      sample      = '0;
	logic                    last_trace  = 1'b0;
	logic                    last_sample = 1'b0;
	logic                    out_valid;
	logic                    out_stall   = 1'b0;
	logic [SW-1:0]           sample_semblance;
	logic [SW-1:0]           window_semblance;
	logic                    window_done;

	// predictor state, wide enough to hold the block's sums
	logic signed [23:0]      amp_acc     = '0;
	logic [39:0]             energy_acc  = '0;
	logic [8:0]              trace_cnt   = '0;
	logic [27:0]             semb_acc    = '0;
	logic [10:0]             window_cnt  = '0;

	coh_word_t               pending_semblance [$];

	bit                      quiet       = 1'b0;
	int unsigned             gap_pct     = 0;
	int unsigned             stall_pct   = 0;
	int unsigned             hold_left   = 0;
	int unsigned             idle_cycles = 0;
	int unsigned             fail_count  = 0;
	int unsigned             words_sent  = 0;
	int unsigned             results_seen = 0;
	int unsigned             windows_closed = 0;
	int unsigned             traces_dropped = 0;
	int unsigned             samples_capped = 0;
	int unsigned             zero_energy = 0;

	semblance_window_average #(
		.MAX_TRACES  (TRACE_CAP),
		.MAX_SAMPLES (SAMPLE_CAP)
	) DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.sample           (sample),
		.last_trace       (last_trace),
		.last_sample      (last_sample),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.sample_semblance (sample_semblance),
		.window_semblance (window_semblance),
		.window_done      (window_done)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void note_fail(input string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS) begin
			$display("[%0t] %s", $time, msg);
		end
	endfunction

	// accumulate one amplitude; returns 1 with the result when the time sample closes
	function automatic logic coherence_step(input logic signed [15:0] amp, input logic lt,
		input logic ls, output coh_word_t res);
		logic signed [31:0] sq;
		longint             sum;
		longint unsigned    mag, num, den;
		logic [SW-1:0]      semb;
		res = '0;
		if (trace_cnt < TRACE_CAP) begin
			sq         = 32'(amp) * 32'(amp);
			amp_acc    = amp_acc + 24'(amp);
			energy_acc = energy_acc + {8'd0, sq};
			trace_cnt  = trace_cnt + 1'b1;
		end else begin
			traces_dropped++;
		end
		if (!lt) begin
			return 1'b0;
		end

		// S*S / (n*E) in Q0.16, truncated
		sum = longint'(amp_acc);
		mag = (sum < 0) ? -sum : sum;
		num = mag * mag;
		den = 64'(trace_cnt) * 64'(energy_acc);
		if (energy_acc == 0) begin
			semb = '0;
			zero_energy++;
		end else if (num >= den) begin
			semb = swa_pkg::SEMB_ONE;
		end else begin
			semb = SW'((num << swa_pkg::SEMB_FRAC) / den);
		end

		// window total saturates in count, not in value
		if (window_cnt < SAMPLE_CAP) begin
			semb_acc   = semb_acc + 28'(semb);
			window_cnt = window_cnt + 1'b1;
		end else begin
			samples_capped++;
		end
		if (ls) begin
			if (window_cnt != 0) begin
				res.win = SW'(semb_acc / 28'(window_cnt));
			end
			semb_acc   = '0;
			window_cnt = '0;
			windows_closed++;
		end
		res.semb   = semb;
		res.done   = ls;
		amp_acc    = '0;
		energy_acc = '0;
		trace_cnt  = '0;
		return 1'b1;
	endfunction

	// drive one word, hold it until taken, then log what it should produce
	task automatic put_word(input logic signed [15:0] amp, input logic lt, input logic ls,
		input logic fixed = 1'b0, input coh_word_t want = '0);
		coh_word_t res;
		if (!quiet && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		sample      <= amp;
		last_trace  <= lt;
		last_sample <= ls;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		words_sent++;
		if (coherence_step(amp, lt, ls, res)) begin
			pending_semblance.push_back(fixed ? want : res);
		end
	endtask

	// one time sample of n_tr traces; stray window marks allowed on inner traces
	task automatic send_time_sample(input int n_tr, input amp_style_t style,
		input logic closes, input logic stray_ok);
		int unsigned        base;
		logic signed [15:0] a;
		logic               ls;
		base = $urandom_range(0, 65535);
		for (int t = 0; t < n_tr; t++) begin
			case (style)
				AMP_ANY: begin
					a = 16'($urandom);
				end
				AMP_COHERENT: begin
					a = 16'(base + $urandom_range(0, 64) - 32);
				end
				AMP_TINY: begin
					a = 16'($urandom_range(0, 8));
					a = a - 16'sd4;
				end
				default: begin
					case ($urandom_range(0, 3))
						0: a = 16'sh8000;
						1: a = 16'sh7FFF;
						2: a = 16'sh0000;
						default: a = 16'shFFFF;
					endcase
				end
			endcase
			if (t == n_tr - 1) begin
				ls = closes;
			end else begin
				ls = stray_ok && ($urandom_range(0, 19) == 0);
			end
			put_word(a, t == n_tr - 1, ls);
		end
	endtask

	// sender holds off until every outstanding result has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_semblance.size() != 0) @(posedge clk);
	endtask

	// compare one taken result against the oldest pending one
	task automatic check_result();
		coh_word_t got, want;
		got = '{sample_semblance, window_semblance, window_done};
		results_seen++;
		if (pending_semblance.size() == 0) begin
			note_fail($sformatf("unexpected result: semb %0d win %0d done %0b",
				got.semb, got.win, got.done));
		end else begin
			want = pending_semblance.pop_front();
			if (got !== want) begin
				note_fail($sformatf("expected semb %0d win %0d done %0b, got semb %0d win %0d done %0b",
					want.semb, want.win, want.done, got.semb, got.win, got.done));
			end
		end
	endtask

	// result side: check taken words, stall in random bursts
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				check_result();
			end
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
				hold_left <= $urandom_range(0, 17);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog on cycles with no word taken on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no word taken for %0d cycles", idle_cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// stimulus
	initial begin
		int unsigned rand_start;
		int          n_ts, n_tr;
		amp_style_t  style;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words
		gap_pct   = 20;
		stall_pct = 20;
		for (int i = 0; i < DIR_N; i++) begin
			put_word(DIR_TAB[i].amp, DIR_TAB[i].lt, DIR_TAB[i].ls, DIR_TAB[i].fixed,
				DIR_TAB[i].want);
		end
		drain_results();

		// trace count running through the cap and past it
		send_time_sample(TRACE_CAP + 4, AMP_COHERENT, 1'b1, 1'b1);

		// random windows; the last fifth runs without idling
		rand_start = words_sent;
		while (words_sent - rand_start < RANDOM_WORDS) begin
			quiet = (words_sent - rand_start >= RANDOM_WORDS * 4 / 5);
			case ($urandom_range(0, 2))
				0: gap_pct = 0;
				1: gap_pct = 10;
				default: gap_pct = 40;
			endcase
			case ($urandom_range(0, 2))
				0: stall_pct = 0;
				1: stall_pct = 10;
				default: stall_pct = 40;
			endcase
			n_ts = $urandom_range(1, 8);
			for (int ts = 0; ts < n_ts; ts++) begin
				if ($urandom_range(0, 15) == 0) begin
					n_tr = $urandom_range(13, 40);
				end else begin
					n_tr = $urandom_range(1, 12);
				end
				style = amp_style_t'($urandom_range(0, 3));
				send_time_sample(n_tr, style, ts == n_ts - 1, 1'b1);
			end
		end
		in_valid <= 1'b0;

		// let the last results through, then watch for strays
		while (pending_semblance.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_semblance.size() != 0) begin
			note_fail($sformatf("%0d results never arrived", pending_semblance.size()));
		end

		$display("Sent %0d words, checked %0d semblances, closed %0d windows (%0d zero-energy).",
			words_sent, results_seen, windows_closed, zero_energy);
		$display("Trace cap dropped %0d words; sample cap left %0d semblances out of a window.",
			traces_dropped, samples_capped);
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
